// ===== rtl/core/cemg_pkg.sv =====
// Shared types, constants and saturating helpers for the GBM level stepper
`default_nettype none
package cemg_pkg;

  localparam int VW          = 48;   // value width, signed
  localparam int FB          = 32;   // fraction bits
  localparam int MAX_LEVELS  = 9;
  localparam int MAX_FINE    = 2048;
  localparam int FI_W        = 12;   // holds 0 .. MAX_FINE
  localparam int LVL_W       = 4;
  localparam int RIDX_W      = 5;    // result index 0 .. 2*MAX_LEVELS-1
  localparam int NRES        = 2 * MAX_LEVELS;
  localparam int CNT_W       = 12;
  localparam int PAY_W       = 47;

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [VW+1:0] wide_t;

  localparam val_t  VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam val_t  VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam wide_t WMAX = {2'b00, VMAX};
  localparam wide_t WMIN = {2'b11, VMIN};
  localparam val_t  ONE  = val_t'(64'd1 << FB);
  localparam val_t  HALF = val_t'(64'd1 << (FB - 1));

  // register indexes on the config port
  localparam logic [2:0] REG_SPOT      = 3'd0;
  localparam logic [2:0] REG_DRIFT     = 3'd1;
  localparam logic [2:0] REG_VOL       = 3'd2;
  localparam logic [2:0] REG_FINE_STEP = 3'd3;
  localparam logic [2:0] REG_LEVELS    = 3'd4;
  localparam logic [2:0] REG_STRIKE    = 3'd5;
  localparam logic [2:0] REG_PUT       = 3'd6;
  localparam logic [2:0] REG_DISCOUNT  = 3'd7;

  // multiply slots of one level step
  localparam logic [2:0] OP_DRIFT_H = 3'd0;
  localparam logic [2:0] OP_VOL_DW  = 3'd1;
  localparam logic [2:0] OP_VOL_SQ  = 3'd2;
  localparam logic [2:0] OP_DW_SQ   = 3'd3;
  localparam logic [2:0] OP_CORR    = 3'd4;
  localparam logic [2:0] OP_HALF    = 3'd5;
  localparam logic [2:0] OP_EULER   = 3'd6;
  localparam logic [2:0] OP_MILST   = 3'd7;

  typedef struct packed {
    logic [46:0]        spot;
    logic signed [47:0] drift;
    logic [46:0]        vol;
    logic [40:0]        fine_step;
    logic [3:0]         levels;
    logic [46:0]        strike;
    logic               put;
    logic [32:0]        discount;
  } cfg_t;

  typedef struct packed {
    val_t val;
    logic ovf;
  } sat_t;

  function automatic sat_t sat_wide(input wide_t x);
    sat_t r;
    r.ovf = 1'b0;
    if (x > WMAX) begin
      r.val = VMAX;
      r.ovf = 1'b1;
    end else if (x < WMIN) begin
      r.val = VMIN;
      r.ovf = 1'b1;
    end else begin
      r.val = x[VW-1:0];
    end
    return r;
  endfunction

  function automatic sat_t add_sat(input val_t a, input val_t b);
    wide_t x;
    x = {{2{a[VW-1]}}, a} + {{2{b[VW-1]}}, b};
    return sat_wide(x);
  endfunction

  function automatic sat_t sub_sat(input val_t a, input val_t b);
    wide_t x;
    x = {{2{a[VW-1]}}, a} - {{2{b[VW-1]}}, b};
    return sat_wide(x);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cemg_mul.sv =====
// Shared fixed-point multiplier: four 24x24 partial products, round, saturate
`default_nettype none
module cemg_mul
  import cemg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire val_t a,
  input  wire val_t b,
  output logic      done,
  output val_t      res,
  output logic      ovf
);

  localparam int HW = VW / 2;
  localparam int PW = 2 * VW;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_PP   = 4'b0010,
    M_RND  = 4'b0100,
    M_SAT  = 4'b1000
  } mstate_t;

  mstate_t           state;
  logic [VW-1:0]     ua, ub;
  logic              neg;
  logic [1:0]        cnt;
  logic [PW-1:0]     acc;
  logic signed [PW:0] rnd;

  logic [HW-1:0]     pa, pb;
  logic [VW-1:0]     pp;
  logic [6:0]        sh;
  logic [PW-FB:0]    q;
  logic [PW-FB:VW-1] qhi;
  logic              fits;

  always_comb begin
    pa   = cnt[1] ? ua[VW-1:HW] : ua[HW-1:0];
    pb   = cnt[0] ? ub[VW-1:HW] : ub[HW-1:0];
    pp   = VW'(pa) * VW'(pb);
    sh   = 7'(HW) * 7'({1'b0, cnt[1]} + {1'b0, cnt[0]});
    q    = rnd[PW:FB];
    qhi  = q[PW-FB:VW-1];
    fits = (&qhi) | ~(|qhi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == M_SAT);
      case (state)
        M_IDLE: begin
          if (start) begin
            ua    <= a[VW-1] ? VW'(-a) : VW'(a);
            ub    <= b[VW-1] ? VW'(-b) : VW'(b);
            neg   <= a[VW-1] ^ b[VW-1];
            acc   <= '0;
            cnt   <= '0;
            state <= M_PP;
          end
        end
        M_PP: begin
          acc <= acc + ({{(PW-VW){1'b0}}, pp} << sh);
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) state <= M_RND;
        end
        M_RND: begin
          rnd   <= (neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc}))
                   + $signed((PW+1)'(1) << (FB - 1));
          state <= M_SAT;
        end
        M_SAT: begin
          if (fits) begin
            res <= q[VW-1:0];
            ovf <= 1'b0;
          end else begin
            res <= q[PW-FB] ? VMIN : VMAX;
            ovf <= 1'b1;
          end
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cemg_core.sv =====
// Level sequencer: block sums, Euler/Milstein steps, payoffs and result output
`default_nettype none
module cemg_core
  import cemg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [47:0] increment,
  input  wire logic               last_of_path,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              level,
  output logic                    method,
  output logic signed [47:0]      terminal,
  output logic [46:0]             payoff_value,
  output logic [11:0]             nonpositive_count,
  output logic signed [47:0]      brownian_sum,
  output logic                    overflow,
  output logic                    misaligned,
  output logic                    final_result
);

  typedef enum logic [7:0] {
    C_IDLE   = 8'b0000_0001,
    C_LEVEL  = 8'b0000_0010,
    C_HSTEP  = 8'b0000_0100,
    C_MISSUE = 8'b0000_1000,
    C_MWAIT  = 8'b0001_0000,
    C_PISSUE = 8'b0010_0000,
    C_PWAIT  = 8'b0100_0000,
    C_EMIT   = 8'b1000_0000
  } cstate_t;

  cstate_t            state;
  logic [FI_W-1:0]    fi;
  val_t               rsum;
  logic               ovf;
  val_t               partial [MAX_LEVELS];
  val_t               eul     [MAX_LEVELS];
  val_t               mil     [MAX_LEVELS];
  logic [CNT_W-1:0]   cnt     [NRES];
  logic [PAY_W-1:0]   pay     [NRES];
  logic [LVL_W-1:0]   lv;
  logic [LVL_W-1:0]   j;
  logic [2:0]         k;
  logic [RIDX_W-1:0]  r;
  val_t               dw;
  logic               last_r;
  val_t               h, base, vsq, tmp, fm;

  logic               mul_start, mul_done, mul_ovf;
  val_t               mul_a, mul_b, mul_res;

  logic [LVL_W-1:0]   lv_in, shift;
  logic [FI_W-1:0]    step_mask, mis_mask;
  logic               step_now, lvl_last, res_last;
  logic [RIDX_W-1:0]  r_last;
  logic [48:0]        hw;
  sat_t               s_sum, s_part, s_one, s_base, s_t, s_fm, s_d;
  val_t               pj, sval, dpos, kval;
  logic [LVL_W-1:0]   rj;
  logic               res_np;

  cemg_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res),
    .ovf   (mul_ovf)
  );

  always_comb begin
    if (cfg.levels == '0)                     lv_in = LVL_W'(1);
    else if (cfg.levels > LVL_W'(MAX_LEVELS)) lv_in = LVL_W'(MAX_LEVELS);
    else                                      lv_in = cfg.levels;
    shift     = lv - LVL_W'(1) - j;
    step_mask = (FI_W'(1) << shift) - FI_W'(1);
    mis_mask  = (FI_W'(1) << (lv - LVL_W'(1))) - FI_W'(1);
    step_now  = (fi & step_mask) == '0;
    lvl_last  = j == lv - LVL_W'(1);
    r_last    = {lv, 1'b0} - RIDX_W'(1);
    res_last  = r == r_last;
    hw        = {8'b0, cfg.fine_step} << shift;
    pj        = partial[j];
    rj        = r[RIDX_W-1:1];
    sval      = r[0] ? mil[rj] : eul[rj];
    kval      = {1'b0, cfg.strike};
    s_sum     = add_sat(rsum, increment);
    s_part    = add_sat(pj, dw);
    s_one     = add_sat(ONE, mul_res);
    s_base    = add_sat(base, mul_res);
    s_t       = sub_sat(mul_res, h);
    s_fm      = add_sat(base, mul_res);
    s_d       = cfg.put ? sub_sat(kval, sval) : sub_sat(sval, kval);
    dpos      = s_d.val[VW-1] ? '0 : s_d.val;
    res_np    = mul_res[VW-1] || (mul_res == '0);
    mul_start = (state == C_MISSUE) || (state == C_PISSUE);
    mul_a     = '0;
    mul_b     = '0;
    if (state == C_PISSUE) begin
      mul_a = {{(VW-33){1'b0}}, cfg.discount};
      mul_b = dpos;
    end else begin
      case (k)
        OP_DRIFT_H: begin mul_a = cfg.drift;      mul_b = h;    end
        OP_VOL_DW:  begin mul_a = {1'b0, cfg.vol}; mul_b = pj;  end
        OP_VOL_SQ:  begin mul_a = {1'b0, cfg.vol}; mul_b = {1'b0, cfg.vol}; end
        OP_DW_SQ:   begin mul_a = pj;             mul_b = pj;   end
        OP_CORR:    begin mul_a = vsq;            mul_b = tmp;  end
        OP_HALF:    begin mul_a = HALF;           mul_b = tmp;  end
        OP_EULER:   begin mul_a = eul[j];         mul_b = base; end
        OP_MILST:   begin mul_a = mil[j];         mul_b = fm;   end
        default:    begin mul_a = '0;             mul_b = '0;   end
      endcase
    end
  end

  assign in_ready = (state == C_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      fi        <= '0;
      rsum      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      j         <= '0;
      k         <= '0;
      r         <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) partial[i] <= '0;
      for (int i = 0; i < NRES; i++)       cnt[i]     <= '0;
    end else begin
      // the output state reloads the word itself
      if (out_valid && out_ready && state != C_EMIT) out_valid <= 1'b0;
      case (state)
        C_IDLE: begin
          if (in_valid) begin
            lv     <= lv_in;
            dw     <= increment;
            last_r <= last_of_path;
            j      <= '0;
            r      <= '0;
            if (fi == '0) begin
              for (int i = 0; i < MAX_LEVELS; i++) begin
                eul[i] <= {1'b0, cfg.spot};
                mil[i] <= {1'b0, cfg.spot};
              end
            end
            if (fi >= FI_W'(MAX_FINE)) begin
              // path too long: word dropped
              ovf   <= 1'b1;
              state <= last_of_path ? C_PISSUE : C_IDLE;
            end else begin
              fi    <= fi + FI_W'(1);
              rsum  <= s_sum.val;
              ovf   <= ovf | s_sum.ovf;
              state <= C_LEVEL;
            end
          end
        end
        C_LEVEL: begin
          partial[j] <= s_part.val;
          ovf        <= ovf | s_part.ovf;
          if (step_now) begin
            state <= C_HSTEP;
          end else if (lvl_last) begin
            state <= last_r ? C_PISSUE : C_IDLE;
          end else begin
            j <= j + LVL_W'(1);
          end
        end
        C_HSTEP: begin
          if (|hw[48:47]) begin
            h   <= VMAX;
            ovf <= 1'b1;
          end else begin
            h <= {1'b0, hw[46:0]};
          end
          k     <= OP_DRIFT_H;
          state <= C_MISSUE;
        end
        C_MISSUE: state <= C_MWAIT;
        C_MWAIT: begin
          if (mul_done) begin
            ovf <= ovf | mul_ovf
                   | ((k == OP_DRIFT_H) & s_one.ovf)
                   | ((k == OP_VOL_DW) & s_base.ovf)
                   | ((k == OP_DW_SQ) & s_t.ovf)
                   | ((k == OP_HALF) & s_fm.ovf);
            case (k)
              OP_DRIFT_H: base <= s_one.val;
              OP_VOL_DW:  base <= s_base.val;
              OP_VOL_SQ:  vsq <= mul_res;
              OP_DW_SQ:   tmp <= s_t.val;
              OP_CORR:    tmp <= mul_res;
              OP_HALF:    fm <= s_fm.val;
              OP_EULER: begin
                eul[j] <= mul_res;
                if (res_np) cnt[{j, 1'b0}] <= cnt[{j, 1'b0}] + CNT_W'(1);
              end
              OP_MILST: begin
                mil[j]     <= mul_res;
                partial[j] <= '0;
                if (res_np) cnt[{j, 1'b1}] <= cnt[{j, 1'b1}] + CNT_W'(1);
              end
              default: ;
            endcase
            if (k == OP_MILST) begin
              if (lvl_last) begin
                state <= last_r ? C_PISSUE : C_IDLE;
              end else begin
                j     <= j + LVL_W'(1);
                state <= C_LEVEL;
              end
            end else begin
              k     <= k + 3'd1;
              state <= C_MISSUE;
            end
          end
        end
        C_PISSUE: begin
          ovf   <= ovf | s_d.ovf;
          state <= C_PWAIT;
        end
        C_PWAIT: begin
          if (mul_done) begin
            ovf    <= ovf | mul_ovf;
            pay[r] <= mul_res[VW-1] ? '0 : mul_res[PAY_W-1:0];
            if (res_last) begin
              r     <= '0;
              state <= C_EMIT;
            end else begin
              r     <= r + RIDX_W'(1);
              state <= C_PISSUE;
            end
          end
        end
        C_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            level             <= rj;
            method            <= r[0];
            terminal          <= sval;
            payoff_value      <= pay[r];
            nonpositive_count <= cnt[r];
            brownian_sum      <= rsum;
            overflow          <= ovf;
            misaligned        <= (fi & mis_mask) != '0;
            final_result      <= res_last;
            if (res_last) begin
              fi    <= '0;
              rsum  <= '0;
              ovf   <= 1'b0;
              for (int i = 0; i < MAX_LEVELS; i++) partial[i] <= '0;
              for (int i = 0; i < NRES; i++)       cnt[i]     <= '0;
              state <= C_IDLE;
            end else begin
              r <= r + RIDX_W'(1);
            end
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/coupled_euler_milstein_gbm_stepper_unit.sv =====
// Top level: config register file and the level stepping core
//
//  channel | signals                                     | dir
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data      | in
//  in      | in_valid in_ready increment last_of_path    | in
//  out     | out_valid out_ready level method terminal   | out
//          | payoff_value nonpositive_count brownian_sum |
//          | overflow misaligned final_result            |
//
// A word runs a block-sum update per level, plus a set-up step and eight multiplies
// on the one shared multiplier for each level whose block completes. A last word
// adds payoff multiplies, two per level, then 2*L result words, one per cycle while
// out_ready is high. Reset is synchronous; no clearing pass. in_ready is low while
// a word is in work; a stalled output holds the sequencer in its output state.
`default_nettype none
module coupled_euler_milstein_gbm_stepper_unit
  import cemg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [47:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [47:0] increment,
  input  wire logic               last_of_path,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              level,
  output logic                    method,
  output logic signed [47:0]      terminal,
  output logic [46:0]             payoff_value,
  output logic [11:0]             nonpositive_count,
  output logic signed [47:0]      brownian_sum,
  output logic                    overflow,
  output logic                    misaligned,
  output logic                    final_result
);

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spot      <= 47'h1_0000_0000;
      cfg.drift     <= '0;
      cfg.vol       <= '0;
      cfg.fine_step <= '0;
      cfg.levels    <= 4'd1;
      cfg.strike    <= 47'h1_0000_0000;
      cfg.put       <= 1'b0;
      cfg.discount  <= 33'h1_0000_0000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SPOT:      cfg.spot      <= cfg_data[46:0];
        REG_DRIFT:     cfg.drift     <= cfg_data;
        REG_VOL:       cfg.vol       <= cfg_data[46:0];
        REG_FINE_STEP: cfg.fine_step <= cfg_data[40:0];
        REG_LEVELS:    cfg.levels    <= cfg_data[3:0];
        REG_STRIKE:    cfg.strike    <= cfg_data[46:0];
        REG_PUT:       cfg.put       <= cfg_data[0];
        REG_DISCOUNT:  cfg.discount  <= cfg_data[32:0];
        default: ;
      endcase
    end
  end

  cemg_core u_core (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .increment         (increment),
    .last_of_path      (last_of_path),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .level             (level),
    .method            (method),
    .terminal          (terminal),
    .payoff_value      (payoff_value),
    .nonpositive_count (nonpositive_count),
    .brownian_sum      (brownian_sum),
    .overflow          (overflow),
    .misaligned        (misaligned),
    .final_result      (final_result)
  );

endmodule
`default_nettype wire

// ===== rtl/core/cemg_checker.sv =====
// Port-level checks on the stepper, bound to the top level
`default_nettype none
module cemg_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               method,
  input wire logic               final_result,
  input wire logic signed [47:0] terminal
);

  // no word may be left over from before reset
  a_out_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output word valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(terminal))
    else $error("stalled output word changed");

  // mid-path results keep the input closed
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !final_result |-> !in_ready)
    else $error("input open while path results pending");

  a_final_milst: assert property (@(posedge clk) disable iff (rst)
    out_valid && final_result |-> method)
    else $error("final word is not the Milstein result");

endmodule

bind coupled_euler_milstein_gbm_stepper_unit cemg_checker u_chk (.*);
`default_nettype wire

// ===== verif/tb_coupled_euler_milstein_gbm_stepper_unit.sv =====
// Self-checking testbench for the coupled Euler/Milstein GBM level stepper
`timescale 1ns / 100ps
module tb_coupled_euler_milstein_gbm_stepper_unit;
  import cemg_pkg::*;

  typedef logic signed [127:0] big_t;

  typedef struct {
    logic [3:0]  lvl;
    logic        meth;
    logic [47:0] term;
    logic [46:0] pay;
    logic [11:0] cnt;
    logic [47:0] bsum;
    logic        ovf;
    logic        mis;
    logic        fin;
  } level_result_t;

  localparam big_t BIG_MAX = (big_t'(1) <<< 47) - 1;
  localparam big_t BIG_MIN = -(big_t'(1) <<< 47);
  localparam int   SETTLE  = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = REG_SPOT;
  logic [47:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [47:0] increment = '0;
  logic               last_of_path = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         level;
  logic               method;
  logic signed [47:0] terminal;
  logic [46:0]        payoff_value;
  logic [11:0]        nonpositive_count;
  logic signed [47:0] brownian_sum;
  logic               overflow;
  logic               misaligned;
  logic               final_result;

  coupled_euler_milstein_gbm_stepper_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .increment(increment),
    .last_of_path(last_of_path),
    .out_valid(out_valid), .out_ready(out_ready), .level(level), .method(method),
    .terminal(terminal), .payoff_value(payoff_value), .nonpositive_count(nonpositive_count),
    .brownian_sum(brownian_sum), .overflow(overflow), .misaligned(misaligned),
    .final_result(final_result)
  );

  // predictor copy of the register file, raw masked values
  logic [47:0] cf [8];

  val_t        eul_v [MAX_LEVELS];
  val_t        mil_v [MAX_LEVELS];
  val_t        part_dw [MAX_LEVELS];
  logic [11:0] np_cnt [NRES];
  int          fine_idx;
  val_t        path_sum;
  logic        sat_seen;

  level_result_t pending_results[$];
  int errors = 0;
  int snd_idle = 0;
  int rcv_idle = 0;

  initial forever #4 clk = ~clk;

  function automatic val_t clamp_v(input big_t x);
    if (x > BIG_MAX) begin
      sat_seen = 1'b1;
      return VMAX;
    end
    if (x < BIG_MIN) begin
      sat_seen = 1'b1;
      return VMIN;
    end
    return x[47:0];
  endfunction

  function automatic val_t add_q(input val_t a, input val_t b);
    big_t x;
    x = a;
    x = x + big_t'(b);
    return clamp_v(x);
  endfunction

  function automatic val_t sub_q(input val_t a, input val_t b);
    big_t x;
    x = a;
    x = x - big_t'(b);
    return clamp_v(x);
  endfunction

  // round half up, floor shift, saturate
  function automatic val_t mul_q(input val_t a, input val_t b);
    big_t p;
    p = big_t'(a) * big_t'(b);
    p = (p + (big_t'(1) <<< (FB - 1))) >>> FB;
    return clamp_v(p);
  endfunction

  function automatic int levels_eff();
    int l;
    l = cf[REG_LEVELS][3:0];
    if (l < 1) l = 1;
    if (l > MAX_LEVELS) l = MAX_LEVELS;
    return l;
  endfunction

  function automatic void clear_path_state();
    for (int j = 0; j < MAX_LEVELS; j++) part_dw[j] = '0;
    for (int j = 0; j < NRES; j++) np_cnt[j] = '0;
    fine_idx = 0;
    path_sum = '0;
    sat_seen = 1'b0;
  endfunction

  function automatic void step_one_level(input int j, input int shift);
    val_t h, drift, vol, dw, base, vsq, corr, fm;
    h = clamp_v(big_t'({87'b0, cf[REG_FINE_STEP][40:0]}) <<< shift);
    drift = clamp_v(big_t'($signed(cf[REG_DRIFT])));
    vol = clamp_v(big_t'({81'b0, cf[REG_VOL][46:0]}));
    dw = part_dw[j];
    base = add_q(add_q(ONE, mul_q(drift, h)), mul_q(vol, dw));
    vsq = mul_q(vol, vol);
    corr = mul_q(HALF, mul_q(vsq, sub_q(mul_q(dw, dw), h)));
    fm = add_q(base, corr);
    eul_v[j] = mul_q(eul_v[j], base);
    mil_v[j] = mul_q(mil_v[j], fm);
    if (eul_v[j] <= 0) np_cnt[2*j] = np_cnt[2*j] + 12'd1;
    if (mil_v[j] <= 0) np_cnt[2*j+1] = np_cnt[2*j+1] + 12'd1;
    part_dw[j] = '0;
  endfunction

  function automatic val_t discounted_payoff(input val_t s);
    val_t k, d, p;
    k = clamp_v(big_t'({81'b0, cf[REG_STRIKE][46:0]}));
    d = cf[REG_PUT][0] ? sub_q(k, s) : sub_q(s, k);
    if (d < 0) d = '0;
    p = mul_q(clamp_v(big_t'({95'b0, cf[REG_DISCOUNT][32:0]})), d);
    return (p < 0) ? val_t'(0) : p;
  endfunction

  function automatic void predict_word(input val_t inc, input logic last);
    int L, shift;
    logic mis;
    val_t pays [NRES];
    level_result_t r;
    L = levels_eff();
    if (fine_idx == 0) begin
      for (int j = 0; j < MAX_LEVELS; j++) begin
        eul_v[j] = clamp_v(big_t'({81'b0, cf[REG_SPOT][46:0]}));
        mil_v[j] = eul_v[j];
      end
    end
    if (fine_idx >= MAX_FINE) begin
      sat_seen = 1'b1;
    end else begin
      fine_idx++;
      path_sum = add_q(path_sum, inc);
      for (int j = 0; j < L; j++) begin
        shift = L - 1 - j;
        part_dw[j] = add_q(part_dw[j], inc);
        if ((fine_idx & ((1 << shift) - 1)) == 0) step_one_level(j, shift);
      end
    end
    if (!last) return;
    mis = (fine_idx & ((1 << (L - 1)) - 1)) != 0;
    for (int j = 0; j < L; j++) begin
      pays[2*j] = discounted_payoff(eul_v[j]);
      pays[2*j+1] = discounted_payoff(mil_v[j]);
    end
    for (int j = 0; j < L; j++) begin
      for (int m = 0; m < 2; m++) begin
        r.lvl = 4'(j);
        r.meth = 1'(m);
        r.term = m ? mil_v[j] : eul_v[j];
        r.pay = pays[2*j+m][46:0];
        r.cnt = np_cnt[2*j+m];
        r.bsum = path_sum;
        r.ovf = sat_seen;
        r.mis = mis;
        r.fin = (j == L - 1) && (m == 1);
        pending_results = {pending_results, r};
      end
    end
    clear_path_state();
  endfunction

  task automatic check_field(input string name, input logic [47:0] e, input logic [47:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, name, e, a);
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none got level %0d method %0d",
                 $time, level, method);
      end else begin
        level_result_t e;
        e = pending_results.pop_front();
        check_field("level", e.lvl, level);
        check_field("method", e.meth, method);
        check_field("terminal", e.term, terminal);
        check_field("payoff_value", e.pay, payoff_value);
        check_field("nonpositive_count", e.cnt, nonpositive_count);
        check_field("brownian_sum", e.bsum, brownian_sum);
        check_field("overflow", e.ovf, overflow);
        check_field("misaligned", e.mis, misaligned);
        check_field("final_result", e.fin, final_result);
      end
    end
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    logic [47:0] mask;
    case (idx)
      REG_SPOT, REG_VOL, REG_STRIKE: mask = {1'b0, {47{1'b1}}};
      REG_DRIFT:     mask = {48{1'b1}};
      REG_FINE_STEP: mask = {7'b0, {41{1'b1}}};
      REG_LEVELS:    mask = 48'hF;
      REG_PUT:       mask = 48'h1;
      default:       mask = {15'b0, {33{1'b1}}};
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cf[idx] = val & mask;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(input logic signed [47:0] inc, input logic last);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    increment <= inc;
    last_of_path <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(inc, last);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [47:0] rand_inc();
    logic signed [47:0] v;
    if ($urandom_range(7) == 0) return rand48();
    v = $urandom_range(32'h8000_0000, 0);
    return v - 48'sh4000_0000;
  endfunction

  task automatic send_path(input int len);
    for (int i = 0; i < len; i++) send_word(rand_inc(), i == len - 1);
  endtask

  task automatic set_market(input logic [47:0] sp, input logic [47:0] dr, input logic [47:0] vo,
                            input logic [47:0] fs, input logic [3:0] lv, input logic [47:0] k,
                            input logic pt, input logic [47:0] df);
    write_reg(REG_SPOT, sp);
    write_reg(REG_DRIFT, dr);
    write_reg(REG_VOL, vo);
    write_reg(REG_FINE_STEP, fs);
    write_reg(REG_LEVELS, lv);
    write_reg(REG_STRIKE, k);
    write_reg(REG_PUT, pt);
    write_reg(REG_DISCOUNT, df);
  endtask

  task automatic test_reset_values();
    send_word(48'sh0_2000_0000, 1'b0);
    send_word(-48'sh0_1000_0000, 1'b1);
    drain();
  endtask

  task automatic test_field_extremes();
    set_market(48'h1_0000_0000, 48'h0_0800_0000, 48'h0_4000_0000, 48'h0_0100_0000, 4'd2,
               48'h1_0000_0000, 1'b0, 48'h0_F000_0000);
    send_word({1'b0, {47{1'b1}}}, 1'b0);
    send_word({1'b1, 47'b0}, 1'b1);
    send_word(48'sh0, 1'b0);
    send_word(-48'sh1, 1'b1);
    drain();
    // put payoff, full discount, zero step with moving increments, saturating spot
    set_market({1'b0, {47{1'b1}}}, {1'b1, 47'b0}, {1'b0, {47{1'b1}}}, 48'h0, 4'd3,
               {1'b0, {47{1'b1}}}, 1'b1, 48'h1_FFFF_FFFF);
    send_path(4);
    send_path(3);
    drain();
    set_market(48'h0, 48'h0, 48'h0_8000_0000, 48'h0_2000_0000, 4'd1, 48'h0, 1'b0, 48'h0);
    send_path(2);
    drain();
    write_reg(REG_DISCOUNT, 48'h1_0000_0000);
    write_reg(REG_VOL, 48'h3_0000_0000);
    send_path(3);
    drain();
  endtask

  task automatic test_level_limits();
    // zero acts as one level, above the maximum acts as the maximum
    set_market(48'h1_0000_0000, 48'h0_1000_0000, 48'h0_3000_0000, 48'h0_0040_0000, 4'd0,
               48'h0_E000_0000, 1'b0, 48'h0_F800_0000);
    send_path(2);
    drain();
    write_reg(REG_LEVELS, 4'd15);
    write_reg(REG_FINE_STEP, {7'b0, {41{1'b1}}});
    send_path(5);
    drain();
    write_reg(REG_LEVELS, 4'd9);
    write_reg(REG_FINE_STEP, 48'h0_0010_0000);
    send_path(32);
    drain();
  endtask

  task automatic test_random_paths(input int target);
    int sent, L, len, lv;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < target) begin
      if ($urandom_range(9) == 0) lv = $urandom_range(15);
      else lv = $urandom_range(4, 1);
      if ($urandom_range(5) == 0) begin
        set_market(rand48(), rand48(), rand48(), rand48(), 4'(lv), rand48(), 1'($urandom),
                   rand48());
      end else begin
        set_market(48'h0_C000_0000 + $urandom_range(32'h8000_0000, 0),
                   48'sh0_1000_0000 - $urandom_range(32'h2000_0000, 0),
                   $urandom_range(32'h8000_0000, 0), $urandom_range(32'h0400_0000, 0), 4'(lv),
                   48'h0_C000_0000 + $urandom_range(32'h8000_0000, 0), 1'($urandom),
                   48'h0_E000_0000 + $urandom_range(32'h2000_0000, 0));
      end
      L = levels_eff();
      if (L > 5) L = 1;
      if ($urandom_range(3) == 0) len = $urandom_range(9, 1);
      else len = (1 << (L - 1)) * $urandom_range(3, 1);
      for (int i = 0; i < len; i++) begin
        send_word(rand_inc(), i == len - 1);
        // hold off once mid path until the queue is empty
        if (!paused && i == 0 && len > 1 && sent > 5) begin
          paused = 1;
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_results.size() != 0) @(posedge clk);
          repeat (SETTLE) @(posedge clk);
        end
      end
      sent += len;
      drain();
    end
  endtask

  initial begin
    cf[REG_SPOT] = 48'h1_0000_0000;
    cf[REG_DRIFT] = '0;
    cf[REG_VOL] = '0;
    cf[REG_FINE_STEP] = '0;
    cf[REG_LEVELS] = 48'd1;
    cf[REG_STRIKE] = 48'h1_0000_0000;
    cf[REG_PUT] = '0;
    cf[REG_DISCOUNT] = 48'h1_0000_0000;
    clear_path_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    snd_idle = 14;
    rcv_idle = 82;
    test_reset_values();
    test_field_extremes();
    test_level_limits();
    test_random_paths(30);
    snd_idle = 82;
    rcv_idle = 14;
    test_random_paths(30);
    snd_idle = 0;
    rcv_idle = 0;
    test_random_paths(30);
    if (errors == 0 && pending_results.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
